@@ sv/assert_macros.svh @@
// Assertion macros used by the list pool RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ sv/pmlm_pkg.sv @@
// Shared constants, codes and memory command types for the list pool
`default_nettype none

package pmlm_pkg;

  localparam int POOL_DEPTH = 4096;
  localparam int LIST_COUNT = 512;
  localparam int ID_W       = 12;
  localparam int CNT_W      = ID_W + 1;
  localparam int LIST_W     = 9;
  localparam int VAL_W      = 32;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [LIST_W-1:0] list_t;
  typedef logic [VAL_W-1:0]  val_t;

  // request codes; the remaining codes are no-ops
  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY    = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_INS_HEAD = 3'd2,
    REQ_INS_TAIL = 3'd3,
    REQ_CHANGE   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_MISSING  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_LIST = 2'd3
  } stat_t;

  // one pool entry
  typedef struct packed {
    id_t   prev;
    id_t   next;
    val_t  value;
    list_t owner;
    logic  live;
  } entry_t;

  // head and tail of one list
  typedef struct packed {
    id_t head;
    id_t tail;
  } list_ent_t;

  // masked write into the entry memory
  typedef struct packed {
    logic   en_prev;
    logic   en_next;
    logic   en_value;
    logic   en_meta;
    id_t    addr;
    entry_t data;
  } ent_wr_t;

  // masked write into the list memory
  typedef struct packed {
    logic      en_head;
    logic      en_tail;
    list_t     addr;
    list_ent_t data;
  } lst_wr_t;

endpackage

`default_nettype wire

@@ sv/pmlm_store.sv @@
// Entry memory and list head/tail memory with masked writes and registered reads
`default_nettype none

module pmlm_store (
  input  wire logic               clk,
  input  wire pmlm_pkg::id_t      ent_rd_addr_a,
  input  wire pmlm_pkg::id_t      ent_rd_addr_b,
  input  wire pmlm_pkg::ent_wr_t  ent_wr,
  output pmlm_pkg::entry_t        ent_rd_a,
  output pmlm_pkg::entry_t        ent_rd_b,
  input  wire pmlm_pkg::list_t    lst_rd_addr,
  input  wire pmlm_pkg::lst_wr_t  lst_wr,
  output pmlm_pkg::list_ent_t     lst_rd
);

  pmlm_pkg::entry_t    ent_mem [pmlm_pkg::POOL_DEPTH];
  pmlm_pkg::list_ent_t lst_mem [pmlm_pkg::LIST_COUNT];

  // entry memory: field-masked write, two registered reads
  always_ff @(posedge clk) begin
    if (ent_wr.en_prev) begin
      ent_mem[ent_wr.addr].prev <= ent_wr.data.prev;
    end
    if (ent_wr.en_next) begin
      ent_mem[ent_wr.addr].next <= ent_wr.data.next;
    end
    if (ent_wr.en_value) begin
      ent_mem[ent_wr.addr].value <= ent_wr.data.value;
    end
    if (ent_wr.en_meta) begin
      ent_mem[ent_wr.addr].owner <= ent_wr.data.owner;
      ent_mem[ent_wr.addr].live  <= ent_wr.data.live;
    end
    ent_rd_a <= ent_mem[ent_rd_addr_a];
    ent_rd_b <= ent_mem[ent_rd_addr_b];
  end

  // list memory: head/tail masked write, one registered read
  always_ff @(posedge clk) begin
    if (lst_wr.en_head) begin
      lst_mem[lst_wr.addr].head <= lst_wr.data.head;
    end
    if (lst_wr.en_tail) begin
      lst_mem[lst_wr.addr].tail <= lst_wr.data.tail;
    end
    lst_rd <= lst_mem[lst_rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/pooled_multi_list_manager.sv @@
// Requests run one at a time: accept, then entry and list read, then a neighbor
// read for a live-entry query, or ST_WR1 and ST_WR2 link repairs for a successful
// insert or delete, then ST_DONE. A new request is accepted only after ST_DONE;
// the read-then-relink sequence uses the single entry memory write port.
// Reset: synchronous; then a pass over every list clears all heads and tails,
// with in_stall high; entry liveness comes from the allocation count instead.
`default_nettype none

module pooled_multi_list_manager (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pmlm_pkg::REQ_W-1:0]    req_type,
  input  wire logic [pmlm_pkg::LIST_W-1:0]   list_id,
  input  wire logic [pmlm_pkg::ID_W-1:0]     item_id,
  input  wire logic signed [pmlm_pkg::VAL_W-1:0] new_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pmlm_pkg::STAT_W-1:0]        status,
  output logic [pmlm_pkg::ID_W-1:0]          new_item_id,
  output logic                               prev_valid,
  output logic signed [pmlm_pkg::VAL_W-1:0]  prev_value,
  output logic                               item_valid,
  output logic signed [pmlm_pkg::VAL_W-1:0]  item_value,
  output logic                               next_valid,
  output logic signed [pmlm_pkg::VAL_W-1:0]  next_value
);

  `include "assert_macros.svh"

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_NBR   = 7'b0001000,
    ST_WR1   = 7'b0010000,
    ST_WR2   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [pmlm_pkg::REQ_W-1:0]  req_r;
  pmlm_pkg::list_t             lid_r;
  pmlm_pkg::id_t               iid_r;
  pmlm_pkg::val_t              nval_r;
  logic [pmlm_pkg::CNT_W-1:0]  last_alloc;
  pmlm_pkg::list_t             clr_idx;
  pmlm_pkg::id_t               p_r;
  pmlm_pkg::id_t               nx_r;

  // pending link repairs
  logic          fix_prev_en;
  pmlm_pkg::id_t fix_prev_addr;
  pmlm_pkg::id_t fix_prev_data;
  logic          fix_next_en;
  pmlm_pkg::id_t fix_next_addr;
  pmlm_pkg::id_t fix_next_data;

  // result waiting for the output register
  logic [pmlm_pkg::STAT_W-1:0] res_status;
  pmlm_pkg::id_t               res_new_id;
  logic                        res_prev_valid;
  pmlm_pkg::val_t              res_prev_value;
  logic                        res_item_valid;
  pmlm_pkg::val_t              res_item_value;
  logic                        res_next_valid;
  pmlm_pkg::val_t              res_next_value;

  pmlm_pkg::id_t       ent_rd_addr_a;
  pmlm_pkg::id_t       ent_rd_addr_b;
  pmlm_pkg::ent_wr_t   ent_wr;
  pmlm_pkg::entry_t    ent_rd_a;
  pmlm_pkg::entry_t    ent_rd_b;
  pmlm_pkg::list_t     lst_rd_addr;
  pmlm_pkg::lst_wr_t   lst_wr;
  pmlm_pkg::list_ent_t lst_rd;

  logic          in_accept;
  logic          out_free;
  logic          iid_live;
  logic          owner_ok;
  logic          lid_bad;
  logic          pool_full;
  logic          ins_req;
  logic          ins_ok;
  logic          at_head;
  logic          h_ok;
  logic          t_ok;
  pmlm_pkg::id_t n_id;

  // id names an entry slot of the pool
  function automatic logic id_ok(input pmlm_pkg::id_t id);
    id_ok = (id != '0) &&
            ({1'b0, id} < pmlm_pkg::CNT_W'(pmlm_pkg::POOL_DEPTH));
  endfunction

  // entry was allocated and not deleted since
  function automatic logic is_live(input pmlm_pkg::id_t id, input logic live_bit,
                                   input logic [pmlm_pkg::CNT_W-1:0] last);
    is_live = id_ok(id) && ({1'b0, id} <= last) && live_bit;
  endfunction

  pmlm_store u_store (
    .clk           (clk),
    .ent_rd_addr_a (ent_rd_addr_a),
    .ent_rd_addr_b (ent_rd_addr_b),
    .ent_wr        (ent_wr),
    .ent_rd_a      (ent_rd_a),
    .ent_rd_b      (ent_rd_b),
    .lst_rd_addr   (lst_rd_addr),
    .lst_wr        (lst_wr),
    .lst_rd        (lst_rd)
  );

  // handshake
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // decode of the request against the data just read
  assign iid_live  = is_live(iid_r, ent_rd_a.live, last_alloc);
  assign owner_ok  = ({1'b0, ent_rd_a.owner} < (pmlm_pkg::LIST_W+1)'(pmlm_pkg::LIST_COUNT));
  assign lid_bad   = ({1'b0, lid_r} >= (pmlm_pkg::LIST_W+1)'(pmlm_pkg::LIST_COUNT));
  assign pool_full = (last_alloc >= pmlm_pkg::CNT_W'(pmlm_pkg::POOL_DEPTH - 1));
  assign ins_req   = (req_r == pmlm_pkg::REQ_INS_HEAD) || (req_r == pmlm_pkg::REQ_INS_TAIL);
  assign ins_ok    = ins_req && !lid_bad && !pool_full;
  assign at_head   = (req_r == pmlm_pkg::REQ_INS_HEAD);
  assign h_ok      = id_ok(lst_rd.head);
  assign t_ok      = id_ok(lst_rd.tail);
  assign n_id      = last_alloc[pmlm_pkg::ID_W-1:0] + 1'b1;

  // read addresses: the request at accept, the neighbors of the entry afterwards
  assign ent_rd_addr_a = (state == ST_IDLE) ? item_id : ent_rd_a.prev;
  assign ent_rd_addr_b = ent_rd_a.next;
  assign lst_rd_addr   = list_id;

  // memory write commands
  always_comb begin
    ent_wr = '0;
    lst_wr = '0;
    case (state)
      ST_CLEAR: begin
        lst_wr.en_head = 1'b1;
        lst_wr.en_tail = 1'b1;
        lst_wr.addr    = clr_idx;
      end
      ST_READ: begin
        case (req_r)
          pmlm_pkg::REQ_DELETE: begin
            if (iid_live) begin
              ent_wr.en_meta    = 1'b1;
              ent_wr.addr       = iid_r;
              ent_wr.data.owner = ent_rd_a.owner;
              ent_wr.data.live  = 1'b0;
              lst_wr.addr       = ent_rd_a.owner;
              if (owner_ok) begin
                if (ent_rd_a.next == '0 && ent_rd_a.prev != '0) begin
                  lst_wr.en_tail   = 1'b1;
                  lst_wr.data.tail = ent_rd_a.prev;
                end
                if (ent_rd_a.prev == '0 && ent_rd_a.next != '0) begin
                  lst_wr.en_head   = 1'b1;
                  lst_wr.data.head = ent_rd_a.next;
                end
                if (ent_rd_a.prev == '0 && ent_rd_a.next == '0) begin
                  lst_wr.en_head = 1'b1;
                  lst_wr.en_tail = 1'b1;
                end
              end
            end
          end
          pmlm_pkg::REQ_INS_HEAD, pmlm_pkg::REQ_INS_TAIL: begin
            if (ins_ok) begin
              ent_wr.en_prev    = 1'b1;
              ent_wr.en_next    = 1'b1;
              ent_wr.en_value   = 1'b1;
              ent_wr.en_meta    = 1'b1;
              ent_wr.addr       = n_id;
              ent_wr.data.prev  = at_head ? '0 : lst_rd.tail;
              ent_wr.data.next  = at_head ? lst_rd.head : '0;
              ent_wr.data.value = {{(pmlm_pkg::VAL_W - pmlm_pkg::ID_W){1'b0}}, n_id};
              ent_wr.data.owner = lid_r;
              ent_wr.data.live  = 1'b1;
              lst_wr.addr       = lid_r;
              lst_wr.data.head  = n_id;
              lst_wr.data.tail  = n_id;
              lst_wr.en_head    = at_head || !t_ok;
              lst_wr.en_tail    = !at_head || !h_ok;
            end
          end
          pmlm_pkg::REQ_CHANGE: begin
            if (iid_live) begin
              ent_wr.en_value   = 1'b1;
              ent_wr.addr       = iid_r;
              ent_wr.data.value = nval_r;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WR1: begin
        if (fix_prev_en) begin
          ent_wr.en_prev   = 1'b1;
          ent_wr.addr      = fix_prev_addr;
          ent_wr.data.prev = fix_prev_data;
        end
      end
      ST_WR2: begin
        if (fix_next_en) begin
          ent_wr.en_next   = 1'b1;
          ent_wr.addr      = fix_next_addr;
          ent_wr.data.next = fix_next_data;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, result and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      last_alloc <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop a result once taken, unless the next one replaces it
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == pmlm_pkg::LIST_W'(pmlm_pkg::LIST_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            req_r          <= req_type;
            lid_r          <= list_id;
            iid_r          <= item_id;
            nval_r         <= new_value;
            res_status     <= pmlm_pkg::STAT_OK;
            res_new_id     <= '0;
            res_prev_valid <= 1'b0;
            res_prev_value <= '0;
            res_item_valid <= 1'b0;
            res_item_value <= '0;
            res_next_valid <= 1'b0;
            res_next_value <= '0;
            state          <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
          case (req_r)
            pmlm_pkg::REQ_QUERY: begin
              if (iid_live) begin
                res_item_valid <= 1'b1;
                res_item_value <= ent_rd_a.value;
                p_r            <= ent_rd_a.prev;
                nx_r           <= ent_rd_a.next;
                state          <= ST_NBR;
              end else begin
                res_status <= pmlm_pkg::STAT_MISSING;
              end
            end
            pmlm_pkg::REQ_DELETE: begin
              if (iid_live) begin
                fix_prev_en   <= id_ok(ent_rd_a.next);
                fix_prev_addr <= ent_rd_a.next;
                fix_prev_data <= ent_rd_a.prev;
                fix_next_en   <= id_ok(ent_rd_a.prev);
                fix_next_addr <= ent_rd_a.prev;
                fix_next_data <= ent_rd_a.next;
                state         <= ST_WR1;
              end else begin
                res_status <= pmlm_pkg::STAT_MISSING;
              end
            end
            pmlm_pkg::REQ_INS_HEAD, pmlm_pkg::REQ_INS_TAIL: begin
              if (lid_bad) begin
                res_status <= pmlm_pkg::STAT_BAD_LIST;
              end else if (pool_full) begin
                res_status <= pmlm_pkg::STAT_FULL;
              end else begin
                last_alloc    <= last_alloc + 1'b1;
                res_new_id    <= n_id;
                fix_prev_en   <= at_head && h_ok;
                fix_prev_addr <= lst_rd.head;
                fix_prev_data <= n_id;
                fix_next_en   <= !at_head && t_ok;
                fix_next_addr <= lst_rd.tail;
                fix_next_data <= n_id;
                state         <= ST_WR1;
              end
            end
            pmlm_pkg::REQ_CHANGE: begin
              if (!iid_live) begin
                res_status <= pmlm_pkg::STAT_MISSING;
              end
            end
            default: begin
            end
          endcase
        end
        ST_NBR: begin
          // neighbors arrive on both read ports
          if (is_live(p_r, ent_rd_a.live, last_alloc)) begin
            res_prev_valid <= 1'b1;
            res_prev_value <= ent_rd_a.value;
          end
          if (is_live(nx_r, ent_rd_b.live, last_alloc)) begin
            res_next_valid <= 1'b1;
            res_next_value <= ent_rd_b.value;
          end
          state <= ST_DONE;
        end
        ST_WR1: begin
          state <= ST_WR2;
        end
        ST_WR2: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hand the result over once the output register is free
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            new_item_id <= res_new_id;
            prev_valid  <= res_prev_valid;
            prev_value  <= res_prev_value;
            item_valid  <= res_item_valid;
            item_value  <= res_item_value;
            next_valid  <= res_next_valid;
            next_value  <= res_next_value;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // allocation never runs past the last pool slot
  `ASSERT_ALWAYS(a_alloc_bound, last_alloc <= pmlm_pkg::CNT_W'(pmlm_pkg::POOL_DEPTH - 1))
  // the null entry is never written
  `ASSERT_SAME(a_no_null_write, ent_wr.en_prev || ent_wr.en_next || ent_wr.en_value || ent_wr.en_meta, ent_wr.addr != '0)
  // a successful insert advances the allocation count by exactly one
  `ASSERT_NEXT(a_alloc_step, state == ST_READ && ins_ok, last_alloc == $past(last_alloc) + 1'b1)
  // an allocated id is reported only with good status
  `ASSERT_SAME(a_new_id_ok, out_valid && new_item_id != '0, status == pmlm_pkg::STAT_OK)
  // a result without a valid item reports no neighbors and a zero item value
  `ASSERT_SAME(a_missing_quiet, out_valid && !item_valid, !prev_valid && !next_valid && item_value == '0)

endmodule

`default_nettype wire

@@ tb/sv/pooled_multi_list_manager_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the pooled multi-list manager: predictor, scoreboard and drivers
module pooled_multi_list_manager_tb;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 960;
  localparam int CALM_ITEMS   = 200;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOT_LISTS    = 8;
  localparam int HOLD_START   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_START   = 5000;
  localparam int CALM_END     = 7000;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // request codes that the block treats as no-ops
  localparam logic [pmlm_pkg::REQ_W-1:0] REQ_NOP_FIRST = 3'd5;
  localparam logic [pmlm_pkg::REQ_W-1:0] REQ_NOP_LAST  = 3'd7;

  typedef struct packed {
    pmlm_pkg::stat_t status;
    pmlm_pkg::id_t   new_id;
    logic            prev_ok;
    pmlm_pkg::val_t  prev_val;
    logic            item_ok;
    pmlm_pkg::val_t  item_val;
    logic            next_ok;
    pmlm_pkg::val_t  next_val;
  } list_result_t;

  // Shadow copy of the list pool plus the queue of results still owed
  class list_pool_scoreboard;
    bit [pmlm_pkg::ID_W-1:0]   link_prev   [pmlm_pkg::POOL_DEPTH];
    bit [pmlm_pkg::ID_W-1:0]   link_next   [pmlm_pkg::POOL_DEPTH];
    bit [pmlm_pkg::VAL_W-1:0]  entry_value [pmlm_pkg::POOL_DEPTH];
    bit                        entry_live  [pmlm_pkg::POOL_DEPTH];
    bit [pmlm_pkg::LIST_W-1:0] entry_owner [pmlm_pkg::POOL_DEPTH];
    bit [pmlm_pkg::ID_W-1:0]   list_head   [pmlm_pkg::LIST_COUNT];
    bit [pmlm_pkg::ID_W-1:0]   list_tail   [pmlm_pkg::LIST_COUNT];
    bit [pmlm_pkg::CNT_W-1:0]  alloc_count;
    list_result_t              pending_results [$];
    int                        error_count;

    function bit is_live(bit [pmlm_pkg::ID_W-1:0] id);
      return id != 0 && entry_live[id];
    endfunction

    // Allocate the next entry and link it at one end of a list
    function pmlm_pkg::stat_t link_new_entry(int lid, bit at_head,
                                             output bit [pmlm_pkg::ID_W-1:0] nid);
      bit [pmlm_pkg::ID_W-1:0] h;
      bit [pmlm_pkg::ID_W-1:0] t;
      nid = '0;
      if (lid >= pmlm_pkg::LIST_COUNT) return pmlm_pkg::STAT_BAD_LIST;
      if (int'(alloc_count) + 1 >= pmlm_pkg::POOL_DEPTH) return pmlm_pkg::STAT_FULL;
      alloc_count++;
      nid = alloc_count[pmlm_pkg::ID_W-1:0];
      entry_value[nid] = pmlm_pkg::VAL_W'(nid);
      entry_live[nid]  = 1'b1;
      entry_owner[nid] = pmlm_pkg::LIST_W'(lid);
      h = list_head[lid];
      t = list_tail[lid];
      if (at_head) begin
        link_prev[nid] = '0;
        link_next[nid] = h;
        if (h != 0) link_prev[h] = nid;
        else list_tail[lid] = nid;
        list_head[lid] = nid;
      end else begin
        link_next[nid] = '0;
        link_prev[nid] = t;
        if (t != 0) link_next[t] = nid;
        else list_head[lid] = nid;
        list_tail[lid] = nid;
      end
      return pmlm_pkg::STAT_OK;
    endfunction

    // Unlink a live entry and repair its list's head and tail
    function void unlink_entry(bit [pmlm_pkg::ID_W-1:0] id);
      bit [pmlm_pkg::ID_W-1:0]   p;
      bit [pmlm_pkg::ID_W-1:0]   nx;
      bit [pmlm_pkg::LIST_W-1:0] o;
      p  = link_prev[id];
      nx = link_next[id];
      o  = entry_owner[id];
      entry_live[id] = 1'b0;
      if (nx != 0) link_prev[nx] = p;
      if (p != 0) link_next[p] = nx;
      if (nx == 0 && p != 0) list_tail[o] = p;
      if (p == 0 && nx != 0) list_head[o] = nx;
      if (p == 0 && nx == 0) begin
        list_head[o] = '0;
        list_tail[o] = '0;
      end
    endfunction

    // Apply one accepted request and queue the result it owes
    function void note_request(logic [pmlm_pkg::REQ_W-1:0] rq, pmlm_pkg::list_t lid,
                               pmlm_pkg::id_t iid, pmlm_pkg::val_t v);
      list_result_t r;
      bit [pmlm_pkg::ID_W-1:0] p;
      bit [pmlm_pkg::ID_W-1:0] nx;
      bit [pmlm_pkg::ID_W-1:0] nid;
      r = '0;
      case (rq)
        pmlm_pkg::REQ_QUERY: begin
          if (!is_live(iid)) begin
            r.status = pmlm_pkg::STAT_MISSING;
          end else begin
            p  = link_prev[iid];
            nx = link_next[iid];
            r.item_ok  = 1'b1;
            r.item_val = entry_value[iid];
            if (is_live(p)) begin
              r.prev_ok  = 1'b1;
              r.prev_val = entry_value[p];
            end
            if (is_live(nx)) begin
              r.next_ok  = 1'b1;
              r.next_val = entry_value[nx];
            end
          end
        end
        pmlm_pkg::REQ_DELETE: begin
          if (!is_live(iid)) r.status = pmlm_pkg::STAT_MISSING;
          else unlink_entry(iid);
        end
        pmlm_pkg::REQ_INS_HEAD, pmlm_pkg::REQ_INS_TAIL: begin
          r.status = link_new_entry(int'(lid), rq == pmlm_pkg::REQ_INS_HEAD, nid);
          r.new_id = nid;
        end
        pmlm_pkg::REQ_CHANGE: begin
          if (!is_live(iid)) r.status = pmlm_pkg::STAT_MISSING;
          else entry_value[iid] = v;
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function string describe(list_result_t r);
      return $sformatf("status=%0d new_id=%0d prev=%b/%h item=%b/%h next=%b/%h",
                       r.status, r.new_id, r.prev_ok, r.prev_val, r.item_ok, r.item_val,
                       r.next_ok, r.next_val);
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(list_result_t act);
      list_result_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none owed: %s", $time, describe(act));
        return;
      end
      want = pending_results.pop_front();
      bad = (act.status !== want.status) || (act.new_id !== want.new_id) ||
            (act.prev_ok !== want.prev_ok) || (act.prev_val !== want.prev_val) ||
            (act.item_ok !== want.item_ok) || (act.item_val !== want.item_val) ||
            (act.next_ok !== want.next_ok) || (act.next_val !== want.next_val);
      if (bad) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $time, describe(want), describe(act));
      end
    endfunction

    // Mostly a live entry, so requests get past the missing-entry check
    function bit [pmlm_pkg::ID_W-1:0] random_live_id();
      bit [pmlm_pkg::ID_W-1:0] id;
      id = pmlm_pkg::ID_W'($urandom);
      if (alloc_count == 0) return id;
      for (int k = 0; k < 8; k++) begin
        id = pmlm_pkg::ID_W'($urandom_range(1, int'(alloc_count)));
        if (entry_live[id]) return id;
      end
      return id;
    endfunction
  endclass

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic [pmlm_pkg::REQ_W-1:0]        req_type  = '0;
  pmlm_pkg::list_t                   list_id   = '0;
  pmlm_pkg::id_t                     item_id   = '0;
  logic signed [pmlm_pkg::VAL_W-1:0] new_value = '0;
  logic                              out_stall = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic [pmlm_pkg::STAT_W-1:0]       status;
  pmlm_pkg::id_t                     new_item_id;
  logic                              prev_valid;
  logic signed [pmlm_pkg::VAL_W-1:0] prev_value;
  logic                              item_valid;
  logic signed [pmlm_pkg::VAL_W-1:0] item_value;
  logic                              next_valid;
  logic signed [pmlm_pkg::VAL_W-1:0] next_value;

  list_pool_scoreboard sb = new;
  bit sender_calm = 1'b0;

  always #6 clk = ~clk;

  pooled_multi_list_manager dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .list_id     (list_id),
    .item_id     (item_id),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .new_item_id (new_item_id),
    .prev_valid  (prev_valid),
    .prev_value  (prev_value),
    .item_valid  (item_valid),
    .item_value  (item_value),
    .next_valid  (next_valid),
    .next_value  (next_value)
  );

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_request(logic [pmlm_pkg::REQ_W-1:0] rq, pmlm_pkg::list_t lid,
                              pmlm_pkg::id_t iid, pmlm_pkg::val_t v);
    in_valid  <= 1'b1;
    req_type  <= rq;
    list_id   <= lid;
    item_id   <= iid;
    new_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rq, lid, iid, v);
    if (!sender_calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic pmlm_pkg::list_t pick_list();
    if ($urandom_range(0, 9) == 0) return pmlm_pkg::list_t'($urandom);
    return pmlm_pkg::list_t'($urandom_range(0, HOT_LISTS - 1));
  endfunction

  function automatic pmlm_pkg::id_t pick_target();
    if ($urandom_range(0, 9) == 0) return pmlm_pkg::id_t'($urandom);
    return sb.random_live_id();
  endfunction

  function automatic pmlm_pkg::val_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests on live entries, with some noise
  task automatic run_mixed(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        send_request(r < 15 ? pmlm_pkg::REQ_INS_HEAD : pmlm_pkg::REQ_INS_TAIL, pick_list(),
                     pmlm_pkg::id_t'($urandom), $urandom);
      else if (r < 55)
        send_request(pmlm_pkg::REQ_QUERY, pmlm_pkg::list_t'($urandom), pick_target(),
                     $urandom);
      else if (r < 70)
        send_request(pmlm_pkg::REQ_DELETE, pmlm_pkg::list_t'($urandom), pick_target(),
                     $urandom);
      else if (r < 85)
        send_request(pmlm_pkg::REQ_CHANGE, pmlm_pkg::list_t'($urandom), pick_target(),
                     pick_value());
      else if (r < 95)
        send_request(pmlm_pkg::REQ_W'($urandom), pmlm_pkg::list_t'($urandom),
                     pmlm_pkg::id_t'($urandom), $urandom);
      else
        send_request(pmlm_pkg::REQ_W'($urandom_range(REQ_NOP_FIRST, REQ_NOP_LAST)),
                     pmlm_pkg::list_t'($urandom), pmlm_pkg::id_t'($urandom), $urandom);
    end
  endtask

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(list_result_t'{pmlm_pkg::stat_t'(status), new_item_id, prev_valid,
                                     prev_value, item_valid, item_value, next_valid,
                                     next_value});
  end

  // Stall the output at random, with one long hold-off and one calm stretch
  initial begin : receiver
    int cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES)
        out_stall <= 1'b1;
      else if (cycle_count >= CALM_START && cycle_count < CALM_END)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("pooled_multi_list_manager_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // missing entries on an empty pool
    send_request(pmlm_pkg::REQ_QUERY, '0, '0, '0);
    send_request(pmlm_pkg::REQ_DELETE, '0, '0, '0);
    send_request(pmlm_pkg::REQ_CHANGE, '1, '1, 32'h1234_5678);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd1, '0);
    // build list 0 as 2,1,5 and list 511 as 4,3
    send_request(pmlm_pkg::REQ_INS_TAIL, '0, '0, '0);
    send_request(pmlm_pkg::REQ_INS_HEAD, '0, '0, '0);
    send_request(pmlm_pkg::REQ_INS_TAIL, '1, '1, '1);
    send_request(pmlm_pkg::REQ_INS_HEAD, '1, '0, '0);
    send_request(pmlm_pkg::REQ_INS_TAIL, '0, '0, '0);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd1, '0);
    // extreme values, then neighbours at middle, head and tail
    send_request(pmlm_pkg::REQ_CHANGE, '0, 12'd1, 32'h7FFF_FFFF);
    send_request(pmlm_pkg::REQ_CHANGE, '0, 12'd2, 32'h8000_0000);
    send_request(pmlm_pkg::REQ_CHANGE, '0, 12'd5, '1);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd1, '0);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd2, '0);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd5, '0);
    // delete middle, head, then the only entry left; then delete again
    send_request(pmlm_pkg::REQ_DELETE, '0, 12'd1, '0);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd2, '0);
    send_request(pmlm_pkg::REQ_DELETE, '0, 12'd2, '0);
    send_request(pmlm_pkg::REQ_DELETE, '0, 12'd5, '0);
    send_request(pmlm_pkg::REQ_DELETE, '0, 12'd5, '0);
    // reuse the emptied list, drop the tail of list 511
    send_request(pmlm_pkg::REQ_INS_TAIL, '0, '0, '0);
    send_request(pmlm_pkg::REQ_QUERY, '0, 12'd6, '0);
    send_request(pmlm_pkg::REQ_DELETE, '1, 12'd3, '0);
    send_request(pmlm_pkg::REQ_QUERY, '1, 12'd4, '0);
    send_request(REQ_NOP_FIRST, '1, '1, '1);
    send_request(REQ_NOP_LAST, '1, '1, '1);

    run_mixed(RANDOM_ITEMS);

    // a long stretch offered back to back
    sender_calm = 1'b1;
    run_mixed(CALM_ITEMS);
    sender_calm = 1'b0;

    // an insert at the head of list 0 and the tail of list 511, then more mixed traffic
    send_request(pmlm_pkg::REQ_INS_HEAD, '0, '0, '0);
    send_request(pmlm_pkg::REQ_INS_TAIL, '1, '1, '1);
    run_mixed(TAIL_ITEMS);

    // drain and let any stray result show up
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0)
      $display("pooled_multi_list_manager_tb: done, clean");
    else
      $display("pooled_multi_list_manager_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/pmlm_pkg.sv
sv/pmlm_store.sv
sv/pooled_multi_list_manager.sv
tb/sv/pooled_multi_list_manager_tb.sv
